// ===== rtl/brm_pkg.sv =====
// ----------------------------------------------------------------------------
// brm_pkg: shared types and constants of the block peak / RMS meter
// Request and result payloads, the job record handed from the accumulator
// to the divide / square-root engine, and the engine state type.
// ----------------------------------------------------------------------------
`default_nettype none

package brm_pkg;

  // field widths
  localparam int SAMPLE_W = 24;
  localparam int CHAN_W   = 6;
  localparam int SQ_W     = 2 * SAMPLE_W;
  localparam int SUM_W    = 64;
  localparam int COUNT_W  = 19;
  localparam int ROOT_W   = SUM_W / 2;

  // sizing of the metering block
  localparam int MAX_BLOCK_SAMPLES = 4096;
  localparam int MAX_CHANNELS      = 64;

  // sample count saturates at the smaller of the block size and the counter range
  localparam longint COUNT_LIMIT_RAW = longint'(MAX_BLOCK_SAMPLES) * longint'(MAX_CHANNELS);
  localparam longint COUNT_RANGE     = (longint'(1) << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] COUNT_CAP =
    COUNT_W'((COUNT_LIMIT_RAW > COUNT_RANGE) ? COUNT_RANGE : COUNT_LIMIT_RAW);

  // full scale magnitude, also the RMS clamp
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = SAMPLE_W'(1) << (SAMPLE_W - 1);

  // iterative engine step counts
  localparam int STEP_W     = 6;
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;

  // job queue between accumulator and engine
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          channel;
    logic                       block_end;
  } req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] peak_all;
    logic [SAMPLE_W-1:0] rms_level;
    logic [SAMPLE_W-1:0] peak_left;
    logic [SAMPLE_W-1:0] peak_right;
  } res_t;

  // one finished metering block waiting for the engine
  typedef struct packed {
    logic [SAMPLE_W-1:0] peak_all;
    logic [SAMPLE_W-1:0] peak_left;
    logic [SAMPLE_W-1:0] peak_right;
    logic [SUM_W-1:0]    square_sum;
    logic [COUNT_W-1:0]  sample_count;
  } job_t;

  // queue write from the accumulator
  typedef struct packed {
    logic push;
  } qwr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_HOLD
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/brm_front.sv =====
// ----------------------------------------------------------------------------
// brm_front: sample accumulator
// Takes one sample a cycle unless a block end meets a full queue, tracks
// peaks, sum of squares and count, and hands a job record to the queue on
// the last sample of a block.
`default_nettype none

module brm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire brm_pkg::req_t req_data,
  output brm_pkg::qwr_t      qwr,
  input  wire logic          q_full,
  output brm_pkg::job_t      job
);

  logic [brm_pkg::SAMPLE_W-1:0] raw;
  logic [brm_pkg::SAMPLE_W-1:0] mag_in;
  logic [brm_pkg::SQ_W-1:0]     sq_in;

  // stage A: magnitude and square
  logic                         a_valid;
  logic [brm_pkg::SAMPLE_W-1:0] a_mag;
  logic [brm_pkg::SQ_W-1:0]     a_sq;
  logic [brm_pkg::CHAN_W-1:0]   a_chan;
  logic                         a_last;

  // running state
  logic [brm_pkg::SAMPLE_W-1:0] peak;
  logic [brm_pkg::SAMPLE_W-1:0] peak_l;
  logic [brm_pkg::SAMPLE_W-1:0] peak_r;
  logic [brm_pkg::SUM_W-1:0]    sum;
  logic [brm_pkg::COUNT_W-1:0]  count;

  logic [brm_pkg::SAMPLE_W-1:0] peak_next;
  logic [brm_pkg::SAMPLE_W-1:0] peak_l_next;
  logic [brm_pkg::SAMPLE_W-1:0] peak_r_next;
  logic [brm_pkg::SUM_W-1:0]    sum_next;
  logic [brm_pkg::COUNT_W-1:0]  count_next;
  logic [brm_pkg::SUM_W:0]      sum_add;
  logic                         measured;
  logic                         consume;

  // magnitude of the incoming sample; full-scale negative maps to 2^23
  always_comb begin
    raw    = req_data.sample;
    mag_in = raw[brm_pkg::SAMPLE_W-1] ? (~raw + brm_pkg::SAMPLE_W'(1)) : raw;
    sq_in  = {{brm_pkg::SAMPLE_W{1'b0}}, mag_in} * {{brm_pkg::SAMPLE_W{1'b0}}, mag_in};
  end

  // stage A drains unless a block end meets a full queue
  assign req_ready = !a_valid || !(a_last && q_full);
  assign consume   = a_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req_ready) begin
      a_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready) begin
      a_mag  <= mag_in;
      a_sq   <= sq_in;
      a_chan <= req_data.channel;
      a_last <= req_data.block_end;
    end
  end

  // accumulate stage A into the running state
  always_comb begin
    measured    = ({1'b0, a_chan} < (brm_pkg::CHAN_W + 1)'(brm_pkg::MAX_CHANNELS));
    peak_next   = peak;
    peak_l_next = peak_l;
    peak_r_next = peak_r;
    sum_next    = sum;
    count_next  = count;
    sum_add     = {1'b0, sum} + (brm_pkg::SUM_W + 1)'(a_sq);
    if (measured) begin
      if (a_mag > peak) begin
        peak_next = a_mag;
      end
      if (a_chan == brm_pkg::CHAN_W'(0) && a_mag > peak_l) begin
        peak_l_next = a_mag;
      end
      if (a_chan == brm_pkg::CHAN_W'(1) && a_mag > peak_r) begin
        peak_r_next = a_mag;
      end
      // saturating sum of squares
      sum_next = sum_add[brm_pkg::SUM_W] ? {brm_pkg::SUM_W{1'b1}}
                                        : sum_add[brm_pkg::SUM_W-1:0];
      if (count < brm_pkg::COUNT_CAP) begin
        count_next = count + brm_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak   <= '0;
      peak_l <= '0;
      peak_r <= '0;
      sum    <= '0;
      count  <= '0;
    end else if (consume) begin
      if (a_last) begin
        peak   <= '0;
        peak_l <= '0;
        peak_r <= '0;
        sum    <= '0;
        count  <= '0;
      end else begin
        peak   <= peak_next;
        peak_l <= peak_l_next;
        peak_r <= peak_r_next;
        sum    <= sum_next;
        count  <= count_next;
      end
    end
  end

  // job record for the engine
  always_comb begin
    qwr.push         = consume && a_last;
    job.peak_all     = peak_next;
    job.peak_left    = peak_l_next;
    job.peak_right   = peak_r_next;
    job.square_sum   = sum_next;
    job.sample_count = count_next;
  end

endmodule

`default_nettype wire

// ===== rtl/brm_queue.sv =====
// ----------------------------------------------------------------------------
// brm_queue: short job queue
// Holds finished blocks between the accumulator and the engine so that
// each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire brm_pkg::qwr_t qwr,
  input  wire brm_pkg::job_t wr_job,
  output logic               full,
  output logic               rd_valid,
  input  wire logic          rd_pop,
  output brm_pkg::job_t      rd_job
);

  brm_pkg::job_t               slots [brm_pkg::QUEUE_DEPTH];
  logic [brm_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [brm_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [brm_pkg::QUEUE_AW:0]   fill;
  logic                         do_push;
  logic                         do_pop;

  assign full     = (fill == (brm_pkg::QUEUE_AW + 1)'(brm_pkg::QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_job   = slots[rd_ptr];
  assign do_push  = qwr.push && !full;
  assign do_pop   = rd_pop && rd_valid;

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + brm_pkg::QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + brm_pkg::QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (brm_pkg::QUEUE_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (brm_pkg::QUEUE_AW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brm_back.sv =====
// ----------------------------------------------------------------------------
// brm_back: mean and square-root engine
// Divides the sum of squares by a nonzero count one quotient bit a cycle, takes
// the integer square root one result bit a cycle, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  output logic               job_pop,
  input  wire brm_pkg::job_t job,
  output logic               res_valid,
  input  wire logic          res_ready,
  output brm_pkg::res_t      res_data
);

  brm_pkg::back_state_t state;
  brm_pkg::back_state_t state_next;

  logic [brm_pkg::STEP_W-1:0]   step;
  logic [brm_pkg::SUM_W-1:0]    work;     // dividend, then quotient, then radicand
  logic [brm_pkg::COUNT_W-1:0]  divisor;
  logic [brm_pkg::COUNT_W-1:0]  rem_d;
  logic [brm_pkg::ROOT_W+1:0]   rem_s;
  logic [brm_pkg::ROOT_W-1:0]   root;
  logic [brm_pkg::SAMPLE_W-1:0] pk_all;
  logic [brm_pkg::SAMPLE_W-1:0] pk_l;
  logic [brm_pkg::SAMPLE_W-1:0] pk_r;

  logic                         step_last;
  logic                         load_res;
  logic                         empty_job;
  logic [brm_pkg::COUNT_W:0]    div_sh;
  logic                         div_ge;
  logic [brm_pkg::ROOT_W+3:0]   sq_sh;
  logic [brm_pkg::ROOT_W+3:0]   sq_trial;
  logic                         sq_ge;
  logic [brm_pkg::SAMPLE_W-1:0] rms_clamped;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      brm_pkg::BK_IDLE: begin
        if (job_valid) begin
          state_next = empty_job ? brm_pkg::BK_HOLD : brm_pkg::BK_DIV;
        end
      end
      brm_pkg::BK_DIV: begin
        if (step_last) begin
          state_next = brm_pkg::BK_SQRT;
        end
      end
      brm_pkg::BK_SQRT: begin
        if (step_last) begin
          state_next = brm_pkg::BK_HOLD;
        end
      end
      brm_pkg::BK_HOLD: begin
        if (load_res) begin
          state_next = brm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = brm_pkg::BK_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    job_pop   = (state == brm_pkg::BK_IDLE) && job_valid;
    load_res  = (state == brm_pkg::BK_HOLD) && (!res_valid || res_ready);
    step_last = (step == '0);
    empty_job = (job.sample_count == '0);
  end

  // one restoring divide step and one square-root step
  always_comb begin
    div_sh   = {rem_d, work[brm_pkg::SUM_W-1]};
    div_ge   = (div_sh >= {1'b0, divisor});
    sq_sh    = {rem_s, work[brm_pkg::SUM_W-1 -: 2]};
    sq_trial = {2'b00, root, 2'b01};
    sq_ge    = (sq_sh >= sq_trial);
    rms_clamped = (root > brm_pkg::ROOT_W'(brm_pkg::FULL_SCALE))
                ? brm_pkg::FULL_SCALE : root[brm_pkg::SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      brm_pkg::BK_IDLE: begin
        if (job_valid) begin
          pk_all  <= job.peak_all;
          pk_l    <= job.peak_left;
          pk_r    <= job.peak_right;
          work    <= job.square_sum;
          divisor <= job.sample_count;
          rem_d   <= '0;
          root    <= '0;
          step    <= brm_pkg::STEP_W'(brm_pkg::DIV_STEPS - 1);
        end
      end
      brm_pkg::BK_DIV: begin
        rem_d <= div_ge ? brm_pkg::COUNT_W'(div_sh - {1'b0, divisor})
                        : div_sh[brm_pkg::COUNT_W-1:0];
        work  <= {work[brm_pkg::SUM_W-2:0], div_ge};
        if (step_last) begin
          rem_s <= '0;
          step  <= brm_pkg::STEP_W'(brm_pkg::SQRT_STEPS - 1);
        end else begin
          step  <= step - brm_pkg::STEP_W'(1);
        end
      end
      brm_pkg::BK_SQRT: begin
        rem_s <= sq_ge ? (brm_pkg::ROOT_W + 2)'(sq_sh - sq_trial)
                       : sq_sh[brm_pkg::ROOT_W+1:0];
        root  <= {root[brm_pkg::ROOT_W-2:0], sq_ge};
        work  <= {work[brm_pkg::SUM_W-3:0], 2'b00};
        step  <= step - brm_pkg::STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_data.peak_all   <= pk_all;
      res_data.rms_level  <= rms_clamped;
      res_data.peak_left  <= pk_l;
      res_data.peak_right <= pk_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/block_peak_rms_meter.sv =====
// ----------------------------------------------------------------------------
// block_peak_rms_meter: block peak and RMS level meter
// Tracks overall, left and right peaks and the mean square of a sample
// block, and reports peaks and floor RMS once the engine is through with it.
// ----------------------------------------------------------------------------
//
//   channel  valid      ready      payload   moves
//   request  req_valid  req_ready  req_data  one sample, channel, block end
//   result   res_valid  res_ready  res_data  peaks and RMS of one block
//
// Samples are taken one per cycle; the accumulator has a two-stage path.
// Each block end costs the engine 64 divide steps, 32 square-root steps and
// its load and hold states. The two-entry job queue lets sampling go on
// while the engine works; samples stall only when a block end finds the
// queue full. Reset clears all running state, the queue and the result
// valid flag; no clearing pass is needed.
`default_nettype none

module block_peak_rms_meter (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire brm_pkg::req_t req_data,
  output logic               res_valid,
  input  wire logic          res_ready,
  output brm_pkg::res_t      res_data
);

  brm_pkg::qwr_t qwr;
  brm_pkg::job_t wr_job;
  brm_pkg::job_t rd_job;
  logic          q_full;
  logic          rd_valid;
  logic          rd_pop;

  brm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .qwr       (qwr),
    .q_full    (q_full),
    .job       (wr_job)
  );

  brm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .qwr      (qwr),
    .wr_job   (wr_job),
    .full     (q_full),
    .rd_valid (rd_valid),
    .rd_pop   (rd_pop),
    .rd_job   (rd_job)
  );

  brm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (rd_valid),
    .job_pop   (rd_pop),
    .job       (rd_job),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire
